// ----- src/plis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_pkg
// Shared types and fixed constants of the power-line interference subtractor.
// ----------------------------------------------------------------------------
package plis_pkg;

  // Fixed field widths of the configuration register and the result.
  localparam int THRESH_BITS = 26;
  localparam int OUT_BITS    = 26;

  // Stored interference estimates are kept scaled by the period length.
  localparam int INTERF_BITS = 30;

  // Reset value of the linearity threshold register.
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 26'd3000;

  // Command codes of an input beat.
  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Control from the pipeline to the estimator stage.
  typedef struct packed {
    logic fire;   // a beat leaves the input register this cycle
    logic clear;  // that beat carries the clear command
  } plis_ctrl_t;

endpackage

// ----- src/plis_estimator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_estimator
// Sample history, per-phase interference estimates and linearity tracking.
// Produces the result value scaled by the period length for one beat.
// ----------------------------------------------------------------------------
module plis_estimator #(
  parameter int SAMPLES_PER_PERIOD = 5,
  parameter int SAMPLE_BITS        = 24,
  parameter int VALUE_BITS         = 31
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plis_pkg::plis_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic [plis_pkg::THRESH_BITS-1:0]     threshold,
  output logic signed [VALUE_BITS-1:0]         est_value
);

  localparam int N   = SAMPLES_PER_PERIOD;
  localparam int S   = SAMPLES_PER_PERIOD > 0 ? SAMPLE_BITS : SAMPLE_BITS;
  localparam int VW  = VALUE_BITS;
  localparam int IB  = plis_pkg::INTERF_BITS;
  localparam int PW  = $clog2(N);
  localparam int CNW = $clog2(N + 1);
  localparam int DW  = S + 2;
  localparam int CW  = (DW > plis_pkg::THRESH_BITS) ? DW : plis_pkg::THRESH_BITS;

  localparam logic signed [VW-1:0] N_V     = VW'(N);
  localparam logic signed [VW-1:0] INT_MAX =
    {{(VW-IB+1){1'b0}}, {(IB-1){1'b1}}};
  localparam logic signed [VW-1:0] INT_MIN =
    {{(VW-IB+1){1'b1}}, {(IB-1){1'b0}}};
  localparam logic [CNW-1:0] CNT_ONE  = CNW'(1);
  localparam logic [CNW-1:0] CNT_FULL = CNW'(N);
  localparam logic [PW-1:0]  PH_LAST  = PW'(N - 1);

  // History: hist_r[k] is the sample k beats back.
  logic signed [S-1:0]  hist_r   [1:N+1];
  logic signed [S-1:0]  hist_nxt [1:N+1];
  logic signed [IB-1:0] interf_r   [N];
  logic signed [IB-1:0] interf_nxt [N];
  logic [PW-1:0]        phase_r, phase_nxt;
  logic [CNW-1:0]       cnt_r, cnt_nxt;

  logic signed [DW-1:0] d1, d2, crit;
  logic [DW-1:0]        crit_abs;
  logic                 linear;
  logic                 update;
  logic signed [VW-1:0] sum;
  logic signed [VW-1:0] diff, half, avg5;
  logic signed [VW-1:0] scaled, interf_cur, resid, new_int;
  logic signed [IB-1:0] new_int_sat;

  // Linearity test on the two one-period differences.
  always_comb begin
    d1       = DW'(hist_r[N]) - DW'(sample);
    d2       = DW'(hist_r[N+1]) - DW'(hist_r[1]);
    crit     = d1 - d2;
    crit_abs = crit[DW-1] ? DW'(-crit) : DW'(crit);
    linear   = CW'(crit_abs) < CW'(threshold);
    update   = linear && (cnt_r <= CNT_ONE);
  end

  // Period average scaled by N: sum of the last period minus half the end step.
  always_comb begin
    sum = '0;
    for (int k = 1; k <= N; k++) begin
      sum = sum + VW'(hist_r[k]);
    end
    diff = VW'(sample) - VW'(hist_r[N]);
    half = (diff + (diff[VW-1] ? VW'(1) : VW'(0))) >>> 1;
    avg5 = sum - half;
  end

  // Delayed sample against the estimate of the current phase.
  always_comb begin
    scaled     = VW'(hist_r[2]) * N_V;
    interf_cur = VW'(interf_r[phase_r]);
    resid      = scaled - interf_cur;
    new_int    = scaled - avg5;
    if (new_int > INT_MAX) begin
      new_int_sat = INT_MAX[IB-1:0];
    end else if (new_int < INT_MIN) begin
      new_int_sat = INT_MIN[IB-1:0];
    end else begin
      new_int_sat = new_int[IB-1:0];
    end
  end

  // A clear beat yields zero, which rounds to a zero result.
  always_comb begin
    if (ctrl.clear == plis_pkg::CMD_CLEAR) begin
      est_value = '0;
    end else if (update) begin
      est_value = avg5;
    end else begin
      est_value = resid;
    end
  end

  // State update for the beat leaving the input register.
  always_comb begin
    hist_nxt   = hist_r;
    interf_nxt = interf_r;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    if (ctrl.fire) begin
      if (ctrl.clear == plis_pkg::CMD_CLEAR) begin
        for (int k = 1; k <= N + 1; k++) begin
          hist_nxt[k] = '0;
        end
        for (int p = 0; p < N; p++) begin
          interf_nxt[p] = '0;
        end
        phase_nxt = '0;
        cnt_nxt   = CNT_ONE;
      end else begin
        hist_nxt[1] = sample;
        for (int k = 2; k <= N + 1; k++) begin
          hist_nxt[k] = hist_r[k-1];
        end
        if (update) begin
          interf_nxt[phase_r] = new_int_sat;
          cnt_nxt             = CNT_ONE;
        end else if (linear) begin
          cnt_nxt = cnt_r - CNT_ONE;
        end else begin
          cnt_nxt = CNT_FULL;
        end
        phase_nxt = (phase_r == PH_LAST) ? '0 : phase_r + PW'(1);
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= N + 1; k++) begin
        hist_r[k] <= '0;
      end
      for (int p = 0; p < N; p++) begin
        interf_r[p] <= '0;
      end
      phase_r <= '0;
      cnt_r   <= CNT_ONE;
    end else begin
      hist_r   <= hist_nxt;
      interf_r <= interf_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The phase counter wraps at the period length.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_LAST)
    else $error("phase counter out of range");

  // The linear run counter stays between one and the period length.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_ONE) && (cnt_r <= CNT_FULL))
    else $error("linear run counter out of range");

  // A clear beat resets the history, phase and run counter.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && (ctrl.clear == plis_pkg::CMD_CLEAR)) |=>
      (phase_r == '0) && (cnt_r == CNT_ONE) && (hist_r[1] == '0))
    else $error("clear beat did not reset the state");
`endif

endmodule

// ----- src/plis_round_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plis_round_div
// Divides a value scaled by the period length back to sample units, rounding
// half up, and saturates to the result width. Division uses an exact
// reciprocal multiply.
// ----------------------------------------------------------------------------
module plis_round_div #(
  parameter int SAMPLES_PER_PERIOD = 5,
  parameter int VALUE_BITS         = 31
) (
  input  logic signed [VALUE_BITS-1:0]          value,
  output logic signed [plis_pkg::OUT_BITS-1:0]  filtered
);

  localparam int N  = SAMPLES_PER_PERIOD;
  localparam int VW = VALUE_BITS;
  localparam int D  = 2 * N;
  localparam int L  = VW + 2;
  localparam int LD = $clog2(D);
  localparam int SH = L + LD;
  localparam int PWD = 2 * L + 1;
  localparam int QW = PWD - SH;
  localparam int RW = QW + 1;
  localparam int OB = plis_pkg::OUT_BITS;

  localparam logic [63:0] MAGIC = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
  localparam logic signed [L-1:0] N_L   = L'(N);
  localparam logic signed [L-1:0] DM1_L = L'(D - 1);
  localparam logic signed [RW-1:0] SAT_HI =
    {{(RW-OB+1){1'b0}}, {(OB-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO =
    {{(RW-OB+1){1'b1}}, {(OB-1){1'b0}}};

  logic signed [L-1:0]  w;
  logic                 neg;
  logic [L-1:0]         u;
  logic [PWD-1:0]       prod;
  logic [QW-1:0]        q;
  logic signed [RW-1:0] r;

  // floor((2v + N) / 2N): fold negatives onto a ceiling of the magnitude.
  always_comb begin
    w    = $signed({value[VW-1], value, 1'b0}) + N_L;
    neg  = w[L-1];
    u    = neg ? L'(DM1_L - w) : L'(w);
    prod = PWD'(u) * PWD'(MAGIC[L:0]);
    q    = prod[PWD-1:SH];
    r    = neg ? -$signed(RW'(q)) : $signed(RW'(q));
  end

  // Saturate to the result range.
  always_comb begin
    if (r > SAT_HI) begin
      filtered = SAT_HI[OB-1:0];
    end else if (r < SAT_LO) begin
      filtered = SAT_LO[OB-1:0];
    end else begin
      filtered = r[OB-1:0];
    end
  end

endmodule

// ----- src/powerline_interference_subtractor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// powerline_interference_subtractor_core
// Mains-hum subtraction for an ECG sample stream.
// ----------------------------------------------------------------------------
// Usage:
// Input beats (in_cmd, in_sample) are taken when in_valid is high and
// in_stall is low. A process beat yields one filtered result, the sample two
// positions back with the mains interference removed; a clear beat wipes the
// history and estimates and yields a zero result.
// Result beats leave on out_filtered and are taken when out_valid is high and
// out_stall is low. The threshold register is written through cfg_data with
// cfg_valid; cfg_ready is always high. Write it only while the block is idle.
// On its way from the accepting edge to the port the beat passes the input,
// estimate and result registers. One beat is accepted every cycle while
// in_stall is low; the per-phase estimate and history are updated in the
// single estimate step, so back-to-back beats see the state of their
// predecessor. A stall on the result side holds the three registers; in_stall
// rises only when all three hold a beat. Reset clears the state, empties the
// pipeline and sets the threshold to 3000.
// ----------------------------------------------------------------------------
module powerline_interference_subtractor_core #(
  parameter int SAMPLES_PER_PERIOD = 5,
  parameter int SAMPLE_BITS        = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [plis_pkg::OUT_BITS-1:0] out_filtered,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [plis_pkg::THRESH_BITS-1:0]     cfg_data
);

  localparam int NB   = $clog2(SAMPLES_PER_PERIOD + 1);
  localparam int VW_A = SAMPLE_BITS + NB + 3;
  localparam int VW_B = plis_pkg::INTERF_BITS + 1;
  localparam int VW   = (VW_A > VW_B) ? VW_A : VW_B;

  logic                                 in_valid_r, in_valid_nxt;
  logic                                 in_cmd_r, in_cmd_nxt;
  logic signed [SAMPLE_BITS-1:0]        in_sample_r, in_sample_nxt;
  logic                                 mid_valid_r, mid_valid_nxt;
  logic signed [VW-1:0]                 mid_value_r, mid_value_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [plis_pkg::OUT_BITS-1:0] out_filtered_r, out_filtered_nxt;
  logic [plis_pkg::THRESH_BITS-1:0]     thresh_r, thresh_nxt;

  logic                                 out_open, mid_open, in_open;
  plis_pkg::plis_ctrl_t                 est_ctrl;
  logic signed [VW-1:0]                 est_value;
  logic signed [plis_pkg::OUT_BITS-1:0] rounded;

  // Each stage may load when it is empty or its beat moves on.
  assign out_open  = !out_valid_r || !out_stall;
  assign mid_open  = !mid_valid_r || out_open;
  assign in_open   = !in_valid_r || mid_open;
  assign in_stall  = !in_open;
  assign out_valid = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign cfg_ready = 1'b1;

  assign est_ctrl.fire  = in_valid_r && mid_open;
  assign est_ctrl.clear = in_cmd_r;

  // Estimate step: history, linearity and per-phase interference.
  plis_estimator #(
    .SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD),
    .SAMPLE_BITS       (SAMPLE_BITS),
    .VALUE_BITS        (VW)
  ) u_estimator (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (est_ctrl),
    .sample   (in_sample_r),
    .threshold(thresh_r),
    .est_value(est_value)
  );

  // Result step: rounding division and saturation.
  plis_round_div #(
    .SAMPLES_PER_PERIOD(SAMPLES_PER_PERIOD),
    .VALUE_BITS        (VW)
  ) u_round_div (
    .value   (mid_value_r),
    .filtered(rounded)
  );

  // Next values of the pipeline and threshold registers.
  always_comb begin
    in_valid_nxt     = in_valid_r;
    in_cmd_nxt       = in_cmd_r;
    in_sample_nxt    = in_sample_r;
    mid_valid_nxt    = mid_valid_r;
    mid_value_nxt    = mid_value_r;
    out_valid_nxt    = out_valid_r;
    out_filtered_nxt = out_filtered_r;
    thresh_nxt       = thresh_r;
    if (in_open) begin
      in_valid_nxt = in_valid;
      if (in_valid) begin
        in_cmd_nxt    = in_cmd;
        in_sample_nxt = in_sample;
      end
    end
    if (mid_open) begin
      mid_valid_nxt = in_valid_r;
      if (in_valid_r) begin
        mid_value_nxt = est_value;
      end
    end
    if (out_open) begin
      out_valid_nxt = mid_valid_r;
      if (mid_valid_r) begin
        out_filtered_nxt = rounded;
      end
    end
    if (cfg_valid && cfg_ready) begin
      thresh_nxt = cfg_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      thresh_r    <= plis_pkg::THRESH_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      mid_valid_r <= mid_valid_nxt;
      out_valid_r <= out_valid_nxt;
      thresh_r    <= thresh_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_cmd_r       <= in_cmd_nxt;
    in_sample_r    <= in_sample_nxt;
    mid_value_r    <= mid_value_nxt;
    out_filtered_r <= out_filtered_nxt;
  end

`ifndef ASSERT_OFF
  // Back-pressure reaches the input only with every stage full and stalled.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && mid_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // A beat in the estimate register moves to the result register when open.
  a_mid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_valid_r && out_open) |=> out_valid_r)
    else $error("estimate beat lost on its way to the result register");

  // A held result keeps its estimate stage from advancing into it.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_filtered_r))
    else $error("result register changed while held");
`endif

endmodule
